// File: sv/btc_pkg.sv
// Bearing tracking controller: shared types, fixed-point constants and the
// arctangent table. No dependencies.
`default_nettype none

package btc_pkg;

  // Vector values carry 30 fraction bits
  localparam int VEC_ONE_BITS = 30;

  localparam logic signed [31:0] INV_GAIN    = 32'sd652032875;
  localparam logic [63:0]        PI_Q30      = 64'd3373259426;
  localparam logic [63:0]        DEG2RAD_Q62 = 64'd8048910509;
  localparam logic [21:0]        RAD2DEG_Q16 = 22'd3754936;

  // Turn constants in 1e-7 degree
  localparam logic signed [33:0] TURN_FULL    = 34'sd3600000000;
  localparam logic signed [33:0] TURN_HALF    = 34'sd1800000000;
  localparam logic signed [33:0] TURN_QUARTER = 34'sd900000000;
  localparam logic signed [33:0] TURN_1H5     = 34'sd5400000000;
  localparam logic signed [33:0] TURN_TWO     = 34'sd7200000000;

  // Degree constants
  localparam logic [8:0]         DEG_FULL_U = 9'd360;
  localparam logic [8:0]         DEG_HALF_U = 9'd180;
  localparam logic signed [10:0] DEG_FULL_S = 11'sd360;
  localparam logic signed [10:0] DEG_HALF_S = 11'sd180;

  // Register map
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_MODE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE_DEG  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DRIVE_SPEED    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEADING_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SATELLITES = 3'd4;

  // Move modes (code 3 behaves as hold)
  localparam logic [1:0] MODE_LIMP  = 2'd0;
  localparam logic [1:0] MODE_TRACK = 2'd2;

  typedef enum logic [2:0] {
    CMD_STOP = 3'd0,
    CMD_FWD  = 3'd1,
    CMD_REV  = 3'd2,
    CMD_HOLD = 3'd3,
    CMD_LIMP = 3'd4
  } drive_cmd_e;

  // Per-item control carried alongside the angles
  typedef struct packed {
    logic [2:0]        neg;      // fold flag per lane: own lat, target lat, delta lon
    logic signed [8:0] cur;      // wrapped compass heading
    logic              fresh;
    logic              sens_ok;  // calibrated and enough satellites
  } item_ctl_t;

  // atan(2^-i) at 30 fraction bits
  function automatic logic [63:0] atan_q30(input int unsigned i);
    logic [63:0] v;
    case (i)
      0:  v = 64'd843314856;
      1:  v = 64'd497837829;
      2:  v = 64'd263043836;
      3:  v = 64'd133525159;
      4:  v = 64'd67021687;
      5:  v = 64'd33543516;
      6:  v = 64'd16775851;
      7:  v = 64'd8388437;
      8:  v = 64'd4194283;
      9:  v = 64'd2097149;
      10: v = 64'd1048576;
      11: v = 64'd524288;
      12: v = 64'd262144;
      13: v = 64'd131072;
      14: v = 64'd65536;
      15: v = 64'd32768;
      16: v = 64'd16384;
      17: v = 64'd8192;
      18: v = 64'd4096;
      19: v = 64'd2048;
      20: v = 64'd1024;
      21: v = 64'd512;
      22: v = 64'd256;
      23: v = 64'd128;
      24: v = 64'd64;
      25: v = 64'd32;
      26: v = 64'd16;
      27: v = 64'd8;
      28: v = 64'd4;
      29: v = 64'd2;
      30: v = 64'd1;
      default: v = 64'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: sv/btc_front.sv
// Front end: takes input transactions, reduces the three angles, converts them
// to radians and classifies sensor status. Depends on btc_pkg.
`default_nettype none

module btc_front import btc_pkg::*; #(
  parameter  int ANGLE_FRAC_BITS = 24,
  localparam int ZW = ANGLE_FRAC_BITS + 4
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic signed [30:0]   own_lat_i,
  input  wire logic signed [31:0]   own_lon_i,
  input  wire logic signed [30:0]   target_lat_i,
  input  wire logic signed [31:0]   target_lon_i,
  input  wire logic [8:0]           current_heading_i,
  input  wire logic [1:0]           mag_calibration_i,
  input  wire logic [5:0]           satellite_count_i,
  input  wire logic                 target_fresh_i,
  input  wire logic [5:0]           min_satellites_i,
  input  wire logic                 q_full_i,
  output logic                      push_o,
  output logic signed [ZW-1:0]      z_olat_o,
  output logic signed [ZW-1:0]      z_tlat_o,
  output logic signed [ZW-1:0]      z_dlon_o,
  output item_ctl_t                 ctl_o
);

  localparam int AFB = ANGLE_FRAC_BITS;
  localparam logic [63:0] KH_W = DEG2RAD_Q62 >> 17;
  localparam logic [63:0] KL_W = DEG2RAD_Q62 & 64'h1ffff;
  localparam logic [15:0] KH = KH_W[15:0];
  localparam logic [16:0] KL = KL_W[16:0];

  // Reduce into [-half, half) turn
  function automatic logic signed [33:0] wrap_turn(input logic signed [33:0] a);
    logic signed [33:0] r;
    if (a >= TURN_1H5)                 r = a - TURN_TWO;
    else if (a >= TURN_HALF)           r = a - TURN_FULL;
    else if (a >= -TURN_HALF)          r = a;
    else if (a >= -TURN_1H5)           r = a + TURN_FULL;
    else                               r = a + TURN_TWO;
    return r;
  endfunction

  logic [5:0] vld_q;
  logic       en;

  // Whole front advances unless the last stage is blocked by a full queue
  assign en         = ~(vld_q[5] & q_full_i);
  assign in_ready_o = en;
  assign push_o     = vld_q[5] & ~q_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[4:0], in_valid_i};
    end
  end

  // Stage 1: capture
  logic signed [30:0] s1_olat_q, s1_tlat_q;
  logic signed [31:0] s1_olon_q, s1_tlon_q;
  logic [8:0]         s1_head_q;
  logic [1:0]         s1_mag_q;
  logic [5:0]         s1_sats_q;
  logic               s1_fresh_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_olat_q  <= own_lat_i;
      s1_olon_q  <= own_lon_i;
      s1_tlat_q  <= target_lat_i;
      s1_tlon_q  <= target_lon_i;
      s1_head_q  <= current_heading_i;
      s1_mag_q   <= mag_calibration_i;
      s1_sats_q  <= satellite_count_i;
      s1_fresh_q <= target_fresh_i;
    end
  end

  // Stage 2: longitude difference, heading wrap, sensor check
  logic signed [33:0] s2_a_q [3];
  item_ctl_t          s2_ctl_q;
  logic [8:0]         head_m;
  logic signed [9:0]  cur_w;
  item_ctl_t          s2_ctl_d;

  always_comb begin
    head_m = (s1_head_q >= DEG_FULL_U) ? s1_head_q - DEG_FULL_U : s1_head_q;
    cur_w  = (head_m > DEG_HALF_U) ? $signed({1'b0, head_m}) - 10'sd360
                                   : $signed({1'b0, head_m});
    s2_ctl_d.neg     = '0;
    s2_ctl_d.cur     = cur_w[8:0];
    s2_ctl_d.fresh   = s1_fresh_q;
    s2_ctl_d.sens_ok = (s1_mag_q != 2'd0) && (s1_sats_q >= min_satellites_i);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_a_q[0] <= {{3{s1_olat_q[30]}}, s1_olat_q};
      s2_a_q[1] <= {{3{s1_tlat_q[30]}}, s1_tlat_q};
      s2_a_q[2] <= {{2{s1_tlon_q[31]}}, s1_tlon_q} - {{2{s1_olon_q[31]}}, s1_olon_q};
      s2_ctl_q  <= s2_ctl_d;
    end
  end

  // Stage 3: modulo one turn
  logic signed [33:0] s3_r_q [3];
  item_ctl_t          s3_ctl_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        s3_r_q[l] <= wrap_turn(s2_a_q[l]);
      end
      s3_ctl_q <= s2_ctl_q;
    end
  end

  // Stage 4: fold into [-90, 90] and split magnitude from sign
  logic [29:0]        s4_m_q [3];
  logic [2:0]         s4_sgn_q;
  item_ctl_t          s4_ctl_q;
  logic [29:0]        m_d [3];
  logic [2:0]         sgn_d, neg_d;
  logic signed [33:0] t_d [3];
  item_ctl_t          ctl4_d;

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if (s3_r_q[l] > TURN_QUARTER) begin
        t_d[l] = TURN_HALF - s3_r_q[l];  neg_d[l] = 1'b1; sgn_d[l] = 1'b1;
      end else if (s3_r_q[l] < -TURN_QUARTER) begin
        t_d[l] = s3_r_q[l] + TURN_HALF;  neg_d[l] = 1'b1; sgn_d[l] = 1'b0;
      end else if (s3_r_q[l] < 0) begin
        t_d[l] = -s3_r_q[l];             neg_d[l] = 1'b0; sgn_d[l] = 1'b1;
      end else begin
        t_d[l] = s3_r_q[l];              neg_d[l] = 1'b0; sgn_d[l] = 1'b0;
      end
      m_d[l] = t_d[l][29:0];
    end
    ctl4_d     = s3_ctl_q;
    ctl4_d.neg = neg_d;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_m_q   <= m_d;
      s4_sgn_q <= sgn_d;
      s4_ctl_q <= ctl4_d;
    end
  end

  // Stage 5: degree-to-radian partial products
  logic [45:0] s5_ph_q [3];
  logic [46:0] s5_pl_q [3];
  logic [2:0]  s5_sgn_q;
  item_ctl_t   s5_ctl_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        s5_ph_q[l] <= 46'(s4_m_q[l]) * 46'(KH);
        s5_pl_q[l] <= 47'(s4_m_q[l]) * 47'(KL);
      end
      s5_sgn_q <= s4_sgn_q;
      s5_ctl_q <= s4_ctl_q;
    end
  end

  // Stage 6: sum, scale and restore sign
  logic signed [ZW-1:0] s6_z_q [3];
  item_ctl_t            s6_ctl_q;
  logic [62:0]          sum_d [3];
  logic signed [ZW-1:0] zu_d [3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      sum_d[l] = {s5_ph_q[l], 17'b0} + 63'(s5_pl_q[l]);
      zu_d[l]  = ZW'(sum_d[l][62 -: AFB+1]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        s6_z_q[l] <= s5_sgn_q[l] ? -zu_d[l] : zu_d[l];
      end
      s6_ctl_q <= s5_ctl_q;
    end
  end

  assign z_olat_o = s6_z_q[0];
  assign z_tlat_o = s6_z_q[1];
  assign z_dlon_o = s6_z_q[2];
  assign ctl_o    = s6_ctl_q;

endmodule

`default_nettype wire

// File: sv/btc_queue.sv
// Short register queue between front and back end.
// Depends on nothing but its parameters.
`default_nettype none

module btc_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] data_i,
  input  wire logic         pop_i,
  output logic [W-1:0]      data_o,
  output logic              full_o,
  output logic              empty_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign data_o  = mem_q[rd_ptr_q];

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 1'b1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH)) else $error("queue fill level beyond depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o |-> (!push_i || pop_i)) else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("pop from empty queue");

  a_fill_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> count_q == $past(count_q) + 1'b1)
    else $error("fill level did not follow a lone push");

endmodule

`default_nettype wire

// File: sv/btc_back.sv
// Back end: pipelined CORDIC sine/cosine, bearing products, CORDIC arctangent,
// degree conversion and drive decision with output register. Depends on btc_pkg.
`default_nettype none

module btc_back import btc_pkg::*; #(
  parameter  int CORDIC_STAGES   = 24,
  parameter  int ANGLE_FRAC_BITS = 24,
  localparam int ZW = ANGLE_FRAC_BITS + 4
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 q_empty_i,
  input  wire logic signed [ZW-1:0] z_olat_i,
  input  wire logic signed [ZW-1:0] z_tlat_i,
  input  wire logic signed [ZW-1:0] z_dlon_i,
  input  wire item_ctl_t            ctl_i,
  output logic                      pop_o,
  input  wire logic [1:0]           move_mode_i,
  input  wire logic [6:0]           tolerance_deg_i,
  input  wire logic [7:0]           drive_speed_i,
  input  wire logic [7:0]           heading_limit_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic signed [8:0]         required_heading_o,
  output logic signed [9:0]         heading_error_o,
  output logic [2:0]                drive_command_o,
  output logic signed [8:0]         drive_value_o
);

  localparam int CS  = CORDIC_STAGES;
  localparam int AFB = ANGLE_FRAC_BITS;
  localparam int VW  = 32;           // sine/cosine vector
  localparam int PW  = 35;           // arctangent vector
  localparam int MW  = AFB + 3;      // angle magnitude
  localparam int L   = 2 * CS + 5;   // registered stages before the output
  localparam logic [63:0] PI_W = PI_Q30 >> (VEC_ONE_BITS - AFB);
  localparam logic signed [ZW-1:0] PI_F = ZW'(PI_W);

  logic            en;
  logic            out_valid_q;
  logic [L-1:0]    vld_q;
  item_ctl_t       ctl_q [L];

  // Pipeline moves whenever the output register can take a new value
  assign en    = ~out_valid_q | out_ready_i;
  assign pop_o = en & ~q_empty_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[L-2:0], ~q_empty_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctl_q[0] <= ctl_i;
      for (int k = 1; k < L; k++) begin
        ctl_q[k] <= ctl_q[k-1];
      end
    end
  end

  // Rotation CORDIC, three lanes, one iteration per stage
  logic signed [VW-1:0] rx_q [CS][3];
  logic signed [VW-1:0] ry_q [CS][3];
  logic signed [ZW-1:0] rz_q [CS][3];
  logic signed [ZW-1:0] z_in [3];

  assign z_in[0] = z_olat_i;
  assign z_in[1] = z_tlat_i;
  assign z_in[2] = z_dlon_i;

  for (genvar i = 0; i < CS; i++) begin : g_rot
    localparam logic [63:0] TAB_W = atan_q30(i) >> (VEC_ONE_BITS - AFB);
    localparam logic signed [ZW-1:0] TAB = ZW'(TAB_W);
    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic signed [VW-1:0] xa, ya, xs, ys;
      logic signed [ZW-1:0] za;
      if (i == 0) begin : g_first
        assign xa = INV_GAIN;
        assign ya = '0;
        assign za = z_in[l];
      end else begin : g_next
        assign xa = rx_q[i-1][l];
        assign ya = ry_q[i-1][l];
        assign za = rz_q[i-1][l];
      end
      assign xs = xa >>> i;
      assign ys = ya >>> i;
      always_ff @(posedge clk_i) begin
        if (en) begin
          if (!za[ZW-1]) begin
            rx_q[i][l] <= xa - ys;
            ry_q[i][l] <= ya + xs;
            rz_q[i][l] <= za - TAB;
          end else begin
            rx_q[i][l] <= xa + ys;
            ry_q[i][l] <= ya - xs;
            rz_q[i][l] <= za + TAB;
          end
        end
      end
    end
  end

  // Undo the fold: cos/sin per lane (0 own lat, 1 target lat, 2 delta lon)
  logic signed [VW-1:0] nc_q [3];
  logic signed [VW-1:0] ns_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int l = 0; l < 3; l++) begin
        nc_q[l] <= ctl_q[CS-1].neg[l] ? -rx_q[CS-1][l] : rx_q[CS-1][l];
        ns_q[l] <= ctl_q[CS-1].neg[l] ? -ry_q[CS-1][l] : ry_q[CS-1][l];
      end
    end
  end

  // First products: ct*sd, co*st, so*ct
  logic signed [63:0]   pa_w, pb_w, pc_w, pd_w;
  logic signed [VW-1:0] pa_q, pb_q, pc_q, cd_q;

  assign pa_w = nc_q[1] * ns_q[2];
  assign pb_w = nc_q[0] * ns_q[1];
  assign pc_w = ns_q[0] * nc_q[1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      pa_q <= VW'(pa_w >>> VEC_ONE_BITS);
      pb_q <= VW'(pb_w >>> VEC_ONE_BITS);
      pc_q <= VW'(pc_w >>> VEC_ONE_BITS);
      cd_q <= nc_q[2];
    end
  end

  // Second product: (so*ct)*cd
  logic signed [VW-1:0] x2_q, yp2_q, pd2_q;

  assign pd_w = pc_q * cd_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      x2_q  <= pa_q;
      yp2_q <= pb_q;
      pd2_q <= VW'(pd_w >>> VEC_ONE_BITS);
    end
  end

  // East and north components
  logic signed [PW-1:0] e3_q, n3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      e3_q <= PW'(x2_q);
      n3_q <= PW'(yp2_q) - PW'(pd2_q);
    end
  end

  // Arctangent set-up: turn the vector into the right half-plane
  logic signed [PW-1:0] px0, py0;
  logic signed [ZW-1:0] pz0;
  logic                 zero0;

  always_comb begin
    zero0 = (e3_q == '0) && (n3_q == '0);
    if (n3_q < 0) begin
      px0 = -n3_q;
      py0 = -e3_q;
      pz0 = (e3_q >= 0) ? PI_F : -PI_F;
    end else begin
      px0 = n3_q;
      py0 = e3_q;
      pz0 = '0;
    end
  end

  // Vectoring CORDIC
  logic signed [PW-1:0] vx_q [CS];
  logic signed [PW-1:0] vy_q [CS];
  logic signed [ZW-1:0] vz_q [CS];
  logic [CS:0]          zr_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      zr_q <= {zr_q[CS-1:0], zero0};
    end
  end

  for (genvar j = 0; j < CS; j++) begin : g_vec
    localparam logic [63:0] TAB_W = atan_q30(j) >> (VEC_ONE_BITS - AFB);
    localparam logic signed [ZW-1:0] TAB = ZW'(TAB_W);
    logic signed [PW-1:0] xa, ya, xs, ys;
    logic signed [ZW-1:0] za;
    if (j == 0) begin : g_first
      assign xa = px0;
      assign ya = py0;
      assign za = pz0;
    end else begin : g_next
      assign xa = vx_q[j-1];
      assign ya = vy_q[j-1];
      assign za = vz_q[j-1];
    end
    assign xs = xa >>> j;
    assign ys = ya >>> j;
    always_ff @(posedge clk_i) begin
      if (en) begin
        if (ya > 0) begin
          vx_q[j] <= xa + ys;
          vy_q[j] <= ya - xs;
          vz_q[j] <= za + TAB;
        end else begin
          vx_q[j] <= xa - ys;
          vy_q[j] <= ya + xs;
          vz_q[j] <= za - TAB;
        end
      end
    end
  end

  // Radians to degrees
  logic signed [ZW-1:0] zabs;
  logic [MW-1:0]        zmag;
  logic [MW+21:0]       dp_q;
  logic                 dsgn_q;

  assign zabs = vz_q[CS-1][ZW-1] ? -vz_q[CS-1] : vz_q[CS-1];
  assign zmag = zabs[MW-1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      dp_q   <= (MW+22)'(zmag) * (MW+22)'(RAD2DEG_Q16);
      dsgn_q <= vz_q[CS-1][ZW-1];
    end
  end

  // Wrap, saturate, compare with compass heading, pick the drive command
  item_ctl_t          fc;
  logic [8:0]         dmag;
  logic signed [10:0] deg, req_a, req_b, req_c, lim, cur, err, err_abs;
  drive_cmd_e         cmd_d;
  logic signed [8:0]  val_d;
  logic signed [8:0]  spd;

  always_comb begin
    fc    = ctl_q[L-1];
    dmag  = dp_q[MW+21 -: 9];
    if (zr_q[CS]) begin
      deg = '0;
    end else if (dsgn_q) begin
      deg = -$signed({2'b0, dmag});
    end else begin
      deg = $signed({2'b0, dmag});
    end
    req_a = deg[10] ? deg + DEG_FULL_S : deg;
    req_b = (req_a > DEG_HALF_S) ? req_a - DEG_FULL_S : req_a;
    lim   = $signed({3'b0, heading_limit_i});
    if (req_b > lim) begin
      req_c = lim;
    end else if (req_b < -lim) begin
      req_c = -lim;
    end else begin
      req_c = req_b;
    end
    cur     = {{2{fc.cur[8]}}, fc.cur};
    err     = req_c - cur;
    err_abs = err[10] ? -err : err;
    spd     = $signed({1'b0, drive_speed_i});
    val_d   = '0;
    if (!fc.fresh) begin
      cmd_d = CMD_STOP;
    end else if ((move_mode_i == MODE_TRACK) && fc.sens_ok) begin
      if ((err_abs < $signed({4'b0, tolerance_deg_i})) || (cur > lim) || (cur < -lim) ||
          (err == '0)) begin
        cmd_d = CMD_STOP;
      end else if (!err[10]) begin
        cmd_d = CMD_FWD;
        val_d = spd;
      end else begin
        cmd_d = CMD_REV;
        val_d = -spd;
      end
    end else if (move_mode_i == MODE_LIMP) begin
      cmd_d = CMD_LIMP;
    end else begin
      cmd_d = CMD_HOLD;
    end
  end

  // Output register
  logic signed [8:0] req_q, val_q;
  logic signed [9:0] err_q;
  drive_cmd_e        cmd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_q[L-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && vld_q[L-1]) begin
      req_q <= req_c[8:0];
      err_q <= err[9:0];
      cmd_q <= cmd_d;
      val_q <= val_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign required_heading_o = req_q;
  assign heading_error_o    = err_q;
  assign drive_command_o    = cmd_q;
  assign drive_value_o      = val_q;

  a_idle_zero_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (cmd_q == CMD_STOP || cmd_q == CMD_HOLD || cmd_q == CMD_LIMP))
      |-> val_q == '0) else $error("nonzero drive without motion command");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[L-1] && !en) |=> vld_q[L-1]) else $error("item lost while stalled");

endmodule

`default_nettype wire

// File: sv/bearing_tracking_controller.sv
// Bearing tracking controller, top level: stream ports, configuration
// registers, front end, queue and back end. Depends on btc_pkg and submodules.
// Path: six front stages, one queue slot, 2*CORDIC_STAGES+5 back stages and
// the output register. Throughput: one item per cycle while results are taken;
// the unrolled CORDIC pipelines set this rate.
// Reset: asynchronous, active low; clears pipeline valids, queue and the
// registers to mode track, tolerance 5, speed 20, limit 170, 3 satellites.
`default_nettype none

module bearing_tracking_controller import btc_pkg::*; #(
  parameter int CORDIC_STAGES   = 24,
  parameter int ANGLE_FRAC_BITS = 24,
  parameter int QUEUE_DEPTH     = 4
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // own_lat[30:0], own_lon[62:31], target_lat[93:63], target_lon[125:94],
  // current_heading[134:126], mag_calibration[136:135],
  // satellite_count[142:137], target_fresh[143]
  input  wire logic [143:0]         s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // required_heading[8:0], heading_error[18:9], drive_command[21:19],
  // drive_value[30:22], zero[31]
  output logic [31:0]               m_axis_tdata,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [7:0]           cfg_wdata_i
);

  localparam int ZW = ANGLE_FRAC_BITS + 4;
  localparam int QW = 3 * ZW + $bits(item_ctl_t);

  // Configuration registers
  logic [1:0] move_mode_q;
  logic [6:0] tolerance_deg_q;
  logic [7:0] drive_speed_q, heading_limit_q;
  logic [5:0] min_satellites_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      move_mode_q      <= MODE_TRACK;
      tolerance_deg_q  <= 7'd5;
      drive_speed_q    <= 8'd20;
      heading_limit_q  <= 8'd170;
      min_satellites_q <= 6'd3;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_MOVE_MODE:      move_mode_q      <= cfg_wdata_i[1:0];
        REG_TOLERANCE_DEG:  tolerance_deg_q  <= cfg_wdata_i[6:0];
        REG_DRIVE_SPEED:    drive_speed_q    <= cfg_wdata_i;
        REG_HEADING_LIMIT:  heading_limit_q  <= cfg_wdata_i;
        REG_MIN_SATELLITES: min_satellites_q <= cfg_wdata_i[5:0];
        default: ;
      endcase
    end
  end

  // Front end
  logic                 q_full, q_empty, push, pop;
  logic signed [ZW-1:0] f_z_olat, f_z_tlat, f_z_dlon;
  item_ctl_t            f_ctl;

  btc_front #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (s_axis_tvalid),
    .in_ready_o        (s_axis_tready),
    .own_lat_i         (s_axis_tdata[30:0]),
    .own_lon_i         (s_axis_tdata[62:31]),
    .target_lat_i      (s_axis_tdata[93:63]),
    .target_lon_i      (s_axis_tdata[125:94]),
    .current_heading_i (s_axis_tdata[134:126]),
    .mag_calibration_i (s_axis_tdata[136:135]),
    .satellite_count_i (s_axis_tdata[142:137]),
    .target_fresh_i    (s_axis_tdata[143]),
    .min_satellites_i  (min_satellites_q),
    .q_full_i          (q_full),
    .push_o            (push),
    .z_olat_o          (f_z_olat),
    .z_tlat_o          (f_z_tlat),
    .z_dlon_o          (f_z_dlon),
    .ctl_o             (f_ctl)
  );

  // Queue between front and back
  logic [QW-1:0] q_wdata, q_rdata;

  assign q_wdata = {f_z_olat, f_z_tlat, f_z_dlon, f_ctl};

  btc_queue #(
    .W     (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (q_wdata),
    .pop_i   (pop),
    .data_o  (q_rdata),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  logic signed [ZW-1:0] b_z_olat, b_z_tlat, b_z_dlon;
  item_ctl_t            b_ctl;

  assign {b_z_olat, b_z_tlat, b_z_dlon, b_ctl} = q_rdata;

  // Back end
  logic signed [8:0] req_heading, drive_value;
  logic signed [9:0] head_err;
  logic [2:0]        drive_cmd;

  btc_back #(
    .CORDIC_STAGES   (CORDIC_STAGES),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_empty_i          (q_empty),
    .z_olat_i           (b_z_olat),
    .z_tlat_i           (b_z_tlat),
    .z_dlon_i           (b_z_dlon),
    .ctl_i              (b_ctl),
    .pop_o              (pop),
    .move_mode_i        (move_mode_q),
    .tolerance_deg_i    (tolerance_deg_q),
    .drive_speed_i      (drive_speed_q),
    .heading_limit_i    (heading_limit_q),
    .out_valid_o        (m_axis_tvalid),
    .out_ready_i        (m_axis_tready),
    .required_heading_o (req_heading),
    .heading_error_o    (head_err),
    .drive_command_o    (drive_cmd),
    .drive_value_o      (drive_value)
  );

  assign m_axis_tdata = {1'b0, drive_value, drive_cmd, head_err, req_heading};

endmodule

`default_nettype wire

// File: sim/bearing_tracking_controller_tb.sv
// Testbench for bearing_tracking_controller: a bit-exact bearing predictor,
// directed and random position fixes, random stalls on both streams.
// Depends on btc_pkg and the RTL of the block.
`timescale 1ns / 1ps

module bearing_tracking_controller_tb;
  import btc_pkg::*;

  localparam int STAGES = 24;
  localparam int AFB    = 24;
  localparam int LAT    = 2 * STAGES + 12;

  typedef struct packed {
    logic [8:0] req;
    logic [9:0] err;
    logic [2:0] cmd;
    logic [8:0] val;
  } steer_t;

  // Scoreboard: predicts each fix and checks results in order
  class bearing_board;
    logic [1:0] mode;
    logic [6:0] tol;
    logic [7:0] speed;
    logic [7:0] limit;
    logic [5:0] min_sats;
    steer_t     pending[$];
    int         errors;
    int         checked;

    function void reset_regs();
      mode = MODE_TRACK; tol = 5; speed = 20; limit = 170; min_sats = 3;
    endfunction

    function void write_reg(logic [2:0] idx, logic [7:0] d);
      case (idx)
        REG_MOVE_MODE:      mode = d[1:0];
        REG_TOLERANCE_DEG:  tol = d[6:0];
        REG_DRIVE_SPEED:    speed = d;
        REG_HEADING_LIMIT:  limit = d;
        REG_MIN_SATELLITES: min_sats = d[5:0];
        default: ;
      endcase
    endfunction

    function longint atan_step(int i);
      return longint'(atan_q30(i)) >>> (30 - AFB);
    endfunction

    // sine and cosine of an angle in 1e-7 degree
    function void trig(longint a, output longint c, output longint s);
      longint r, x, y, z, xs, ys;
      longint unsigned m;
      bit neg;
      r = a % 64'sd3600000000; x = 652032875; y = 0; neg = 0;
      if (r >= 64'sd1800000000) r -= 64'sd3600000000;
      if (r < -64'sd1800000000) r += 64'sd3600000000;
      if (r > 64'sd900000000) begin r -= 64'sd1800000000; neg = 1; end
      else if (r < -64'sd900000000) begin r += 64'sd1800000000; neg = 1; end
      m = (r < 0) ? -r : r;
      z = longint'((m * 64'd8048910509) >> (62 - AFB));
      if (r < 0) z = -z;
      for (int i = 0; i < STAGES; i++) begin
        xs = x >>> i; ys = y >>> i;
        if (z >= 0) begin x -= ys; y += xs; z -= atan_step(i); end
        else begin x += ys; y -= xs; z += atan_step(i); end
      end
      c = neg ? -x : x;
      s = neg ? -y : y;
    endfunction

    function longint bearing(longint e, longint n);
      longint px, py, z, xs, ys, pi_f, d;
      longint unsigned m;
      px = n; py = e; z = 0;
      pi_f = longint'(PI_Q30) >>> (30 - AFB);
      if (px == 0 && py == 0) return 0;
      if (px < 0) begin
        z = (py >= 0) ? pi_f : -pi_f; px = -px; py = -py;
      end
      for (int i = 0; i < STAGES; i++) begin
        xs = px >>> i; ys = py >>> i;
        if (py > 0) begin px += ys; py -= xs; z += atan_step(i); end
        else begin px -= ys; py += xs; z -= atan_step(i); end
      end
      m = (z < 0) ? -z : z;
      d = longint'((m * 64'd3754936) >> (AFB + 16));
      return (z < 0) ? -d : d;
    endfunction

    function void note_fix(logic [143:0] t);
      longint olat, olon, tlat, tlon, co, so, ct, st, cd, sd, x, y;
      longint req, cur, err, lim, val, a;
      drive_cmd_e cmd;
      steer_t r;
      olat = longint'($signed(t[30:0]));
      olon = longint'($signed(t[62:31]));
      tlat = longint'($signed(t[93:63]));
      tlon = longint'($signed(t[125:94]));
      trig(olat, co, so);
      trig(tlat, ct, st);
      trig(tlon - olon, cd, sd);
      x = (ct * sd) >>> 30;
      y = ((co * st) >>> 30) - ((((so * ct) >>> 30) * cd) >>> 30);
      req = ((bearing(x, y) % 360) + 360) % 360;
      if (req > 180) req -= 360;
      lim = limit;
      if (req > lim) req = lim;
      else if (req < -lim) req = -lim;
      cur = t[134:126] % 360;
      if (cur > 180) cur -= 360;
      err = req - cur;
      val = 0;
      if (!t[143]) cmd = CMD_STOP;
      else if (mode == MODE_TRACK && t[136:135] != 0 && t[142:137] >= min_sats) begin
        a = (err < 0) ? -err : err;
        if (a < tol || cur > lim || cur < -lim || err == 0) cmd = CMD_STOP;
        else if (err > 0) begin cmd = CMD_FWD; val = speed; end
        else begin cmd = CMD_REV; val = -longint'(speed); end
      end else cmd = (mode == MODE_LIMP) ? CMD_LIMP : CMD_HOLD;
      r.req = req[8:0]; r.err = err[9:0]; r.cmd = cmd; r.val = val[8:0];
      pending.push_back(r);
    endfunction

    task report(string what, int got, int want);
      $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want, checked);
      errors++;
    endtask

    task check_result(logic [31:0] d);
      steer_t e;
      if (pending.size() == 0) begin
        report("unexpected result", int'(d), -1);
        return;
      end
      e = pending.pop_front();
      if (d[8:0] != e.req) report("required_heading", $signed(d[8:0]), $signed(e.req));
      if (d[18:9] != e.err) report("heading_error", $signed(d[18:9]), $signed(e.err));
      if (d[21:19] != e.cmd) report("drive_command", d[21:19], e.cmd);
      if (d[30:22] != e.val) report("drive_value", $signed(d[30:22]), $signed(e.val));
      if (d[31]) report("pad bit", 1, 0);
      checked++;
    endtask
  endclass

  logic clk_i, rst_ni;
  logic s_axis_tvalid, s_axis_tready, m_axis_tvalid, m_axis_tready;
  logic [143:0] s_axis_tdata;
  logic [31:0] m_axis_tdata;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [7:0] cfg_wdata_i;

  bearing_board board;
  bit calm_in, calm_out;
  int fixes_sent;

  bearing_tracking_controller DUT (.*);

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("Mismatches found");
    $finish;
  end

  // result side: random back-pressure, check on each transaction
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) board.check_result(m_axis_tdata);
      m_axis_tready <= calm_out || ($urandom_range(99) >= 10);
    end
  end

  // valid stays high from one transaction to the next unless the sender idles
  task send_fix(logic [143:0] t);
    while (!calm_in && $urandom_range(99) < 10) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= t;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_fix(t);
    fixes_sent++;
  endtask

  function automatic logic [143:0] pack_fix(longint olat, longint olon, longint tlat,
      longint tlon, int head, int mag, int sats, bit fresh);
    logic [143:0] t;
    t = '0;
    t[30:0] = olat[30:0]; t[62:31] = olon[31:0];
    t[93:63] = tlat[30:0]; t[125:94] = tlon[31:0];
    t[134:126] = head[8:0]; t[136:135] = mag[1:0];
    t[142:137] = sats[5:0]; t[143] = fresh;
    return t;
  endfunction

  task wait_drained();
    s_axis_tvalid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (LAT + 4) @(posedge clk_i);
  endtask

  task write_reg(logic [2:0] idx, logic [7:0] d);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_wdata_i <= d;
    @(posedge clk_i);
    board.write_reg(idx, d);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic longint rnd_lat();
    return longint'($urandom_range(1800000000)) - 900000000;
  endfunction

  function automatic longint rnd_lon();
    return longint'($urandom_range(32'd3600000000)) - 64'sd1800000000;
  endfunction

  // random fix: mostly near positions, some anywhere, some raw bit patterns
  task random_fix();
    longint olat, olon, tlat, tlon;
    int pick;
    pick = $urandom_range(9);
    olat = rnd_lat(); olon = rnd_lon();
    if (pick < 5) begin
      tlat = olat + $signed($urandom_range(2000000)) - 1000000;
      tlon = olon + $signed($urandom_range(2000000)) - 1000000;
    end else if (pick < 8) begin
      tlat = rnd_lat(); tlon = rnd_lon();
    end else begin
      olat = $signed({$urandom, $urandom}); olon = $signed({$urandom, $urandom});
      tlat = $signed({$urandom, $urandom}); tlon = $signed({$urandom, $urandom});
    end
    send_fix(pack_fix(olat, olon, tlat, tlon,
        ($urandom_range(9) == 0) ? $urandom_range(511) : $urandom_range(359),
        $urandom_range(3), $urandom_range(63), $urandom_range(9) != 0));
  endtask

  initial begin
    board = new();
    board.reset_regs();
    board.errors = 0; board.checked = 0;
    fixes_sent = 0; calm_in = 0; calm_out = 0;
    rst_ni = 1'b0; s_axis_tvalid = 1'b0; s_axis_tdata = '0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_wdata_i = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: extremes, same position, stale target, headings past 360
    send_fix(pack_fix(0, 0, 0, 0, 0, 3, 63, 1));
    send_fix(pack_fix(900000000, 1800000000, -900000000, -1800000000, 359, 3, 63, 1));
    send_fix(pack_fix(-900000000, -1800000000, 900000000, 1800000000, 180, 1, 3, 1));
    send_fix(pack_fix(0, 0, 10000000, 0, 0, 1, 3, 1));
    send_fix(pack_fix(0, 0, 0, 10000000, 0, 1, 3, 1));
    send_fix(pack_fix(0, 0, -10000000, 0, 90, 1, 3, 1));
    send_fix(pack_fix(0, 0, 0, -10000000, 200, 1, 3, 1));
    send_fix(pack_fix(0, 0, 0, -10000000, 511, 2, 3, 1));
    send_fix(pack_fix(0, 0, 0, 10000000, 450, 2, 3, 0));
    send_fix(pack_fix(100, 200, 100, 200, 3, 2, 3, 1));
    send_fix(pack_fix(0, 0, 0, 10000000, 90, 0, 10, 1));
    send_fix(pack_fix(0, 0, 0, 10000000, 88, 1, 2, 1));
    send_fix(pack_fix(-1073741824, -2147483648, 1073741823, 2147483647, 170, 3, 0, 1));
    send_fix(pack_fix(1073741823, 2147483647, -1073741824, -2147483648, 171, 3, 9, 1));
    // pause until everything is back
    wait_drained();

    // phases through register settings, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin write_reg(REG_MOVE_MODE, 2); write_reg(REG_TOLERANCE_DEG, 0);
             write_reg(REG_DRIVE_SPEED, 180); write_reg(REG_HEADING_LIMIT, 180);
             write_reg(REG_MIN_SATELLITES, 0); end
        1: begin write_reg(REG_TOLERANCE_DEG, 127); write_reg(REG_DRIVE_SPEED, 255);
             write_reg(REG_HEADING_LIMIT, 0); write_reg(REG_MIN_SATELLITES, 63); end
        2: begin write_reg(REG_MOVE_MODE, 0); write_reg(REG_HEADING_LIMIT, 255); end
        3: begin write_reg(REG_MOVE_MODE, 1); write_reg(REG_MIN_SATELLITES, 20); end
        4: begin write_reg(REG_MOVE_MODE, 3); write_reg(3'd7, 8'hff); end
        default: begin
          write_reg(REG_MOVE_MODE, 2);
          write_reg(REG_TOLERANCE_DEG, $urandom_range(90));
          write_reg(REG_DRIVE_SPEED, $urandom_range(255));
          write_reg(REG_HEADING_LIMIT, $urandom_range(255));
          write_reg(REG_MIN_SATELLITES, $urandom_range(8));
        end
      endcase
      calm_in = (ph == 6); calm_out = (ph == 6);
      repeat (60) random_fix();
      wait_drained();
    end

    $display("Sent %0d fixes over eight register settings, %0d results checked.",
        fixes_sent, board.checked);
    if (board.errors == 0 && board.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

// File: filelist.f
sv/btc_pkg.sv
sv/btc_front.sv
sv/btc_queue.sv
sv/btc_back.sv
sv/bearing_tracking_controller.sv
sim/bearing_tracking_controller_tb.sv
